### sv/ile_pkg.sv
// Shared codes, widths and types of the indexed list engine.
`timescale 1ns / 1ps
`default_nettype none
package ile_pkg;

    // Field widths of the item and result ports
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Parameter defaults
    localparam int CAPACITY_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd4;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE,
        OP_READ,
        OP_WRITE,
        OP_FIND,
        OP_CLEAR,
        OP_NOP
    } t_op;

    // Classified item passed from front to back (handle travels alongside)
    typedef struct packed {
        t_op              op;
        logic             null_h;
        logic [POS_W-1:0] pos;
    } t_ctl;

endpackage
`default_nettype wire

### sv/ile_front.sv
// Front end: decodes incoming items and buffers them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module ile_front #(
    parameter int STORE_BITS = ile_pkg::HANDLE_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic [ile_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [ile_pkg::POS_W-1:0]    i_position,
    input  wire logic [ile_pkg::HANDLE_W-1:0] i_handle,
    output logic                              o_valid,
    input  wire logic                         i_pop,
    output ile_pkg::t_ctl                     o_ctl,
    output logic [STORE_BITS-1:0]             o_handle
);
    import ile_pkg::*;

    t_ctl                  r_q_ctl [2];
    logic [STORE_BITS-1:0] r_q_h   [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;

    logic [STORE_BITS-1:0] h_masked;
    t_ctl                  dec;
    logic                  do_push;
    logic                  do_pop;

    // Handle is taken modulo 2^STORE_BITS; zero is null
    assign h_masked = i_handle[STORE_BITS-1:0];

    always_comb begin
        dec.null_h = (h_masked == '0);
        dec.pos    = i_position;
        case (i_cmd)
            CMD_APPEND: dec.op = OP_APPEND;
            CMD_INSERT: dec.op = OP_INSERT;
            CMD_REMOVE: dec.op = OP_REMOVE;
            CMD_READ:   dec.op = OP_READ;
            CMD_WRITE:  dec.op = OP_WRITE;
            CMD_FIND:   dec.op = OP_FIND;
            CMD_CLEAR:  dec.op = OP_CLEAR;
            default:    dec.op = OP_NOP;
        endcase
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;
    assign o_ctl    = r_q_ctl[r_rp];
    assign o_handle = r_q_h[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q_ctl[r_wp] <= dec;
            r_q_h[r_wp]   <= h_masked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/ile_back.sv
// Back end: entry store, list walk sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module ile_back #(
    parameter int CAPACITY   = ile_pkg::CAPACITY_DEF,
    parameter int STORE_BITS = ile_pkg::HANDLE_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    output logic                              o_q_pop,
    input  wire ile_pkg::t_ctl                i_ctl,
    input  wire logic [STORE_BITS-1:0]        i_handle,
    output logic                              o_res_valid,
    input  wire logic                         i_res_pop,
    output logic [ile_pkg::STATUS_W-1:0]      o_status,
    output logic [ile_pkg::HANDLE_W-1:0]      o_handle_out,
    output logic [ile_pkg::POS_W-1:0]         o_found_at,
    output logic [ile_pkg::COUNT_W-1:0]       o_count
);
    import ile_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_INS_SHIFT = 7'b0000010,
        S_INS_PLACE = 7'b0000100,
        S_RM_GRAB   = 7'b0001000,
        S_RM_SHIFT  = 7'b0010000,
        S_RD_WAIT   = 7'b0100000,
        S_FIND      = 7'b1000000
    } t_state;

    // Entry store
    logic [STORE_BITS-1:0] mem [CAPACITY];
    logic [STORE_BITS-1:0] r_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [STORE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_pos, n_pos;
    logic [STORE_BITS-1:0] r_h, n_h;
    logic [STORE_BITS-1:0] r_hout, n_hout;

    logic                  r_res_valid, n_res_valid;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [STORE_BITS-1:0] r_res_hout, n_res_hout;
    logic [CW-1:0]         r_res_where, n_res_where;
    logic [CW-1:0]         r_res_count, n_res_count;

    logic                  fin;
    logic [STATUS_W-1:0]   fin_status;
    logic [STORE_BITS-1:0] fin_hout;
    logic [CW-1:0]         fin_where;

    logic                  slot_free;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         cnt_w;
    logic [CW-1:0]         pos_c;
    logic [CW-1:0]         cnt_dn1;
    logic [CW-1:0]         cnt_up1;
    logic [CW-1:0]         idx_dn1;
    logic [CW-1:0]         idx_dn2;
    logic [CW-1:0]         idx_up1;
    logic [CW-1:0]         idx_up2;
    logic [CW-1:0]         rpos_up1;

    assign slot_free = !r_res_valid || i_res_pop;
    assign pos_w     = PW'(i_ctl.pos);
    assign cnt_w     = PW'(r_count);
    assign pos_c     = pos_w[CW-1:0];
    assign cnt_dn1   = r_count - CW'(1);
    assign cnt_up1   = r_count + CW'(1);
    assign idx_dn1   = r_idx - CW'(1);
    assign idx_dn2   = r_idx - CW'(2);
    assign idx_up1   = r_idx + CW'(1);
    assign idx_up2   = r_idx + CW'(2);
    assign rpos_up1  = r_pos + CW'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_h        = r_h;
        n_hout     = r_hout;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;
        o_q_pop    = 1'b0;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_hout   = '0;
        fin_where  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_q_pop = 1'b1;
                    n_h     = i_handle;
                    n_pos   = pos_c;
                    case (i_ctl.op)
                        OP_APPEND: begin
                            fin = 1'b1;
                            if (i_ctl.null_h) begin
                                fin_status = ST_NULL;
                            end else if (r_count == CW'(CAPACITY)) begin
                                fin_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = i_handle;
                                n_count   = cnt_up1;
                            end
                        end
                        OP_INSERT: begin
                            if (i_ctl.null_h) begin
                                fin        = 1'b1;
                                fin_status = ST_NULL;
                            end else if (pos_w > cnt_w) begin
                                fin        = 1'b1;
                                fin_status = ST_BADPOS;
                            end else if (r_count == CW'(CAPACITY)) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else if (pos_w == cnt_w) begin
                                // insert at the end is an append
                                fin       = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = i_handle;
                                n_count   = cnt_up1;
                            end else begin
                                mem_raddr = cnt_dn1[AW-1:0];
                                n_idx     = r_count;
                                n_state   = S_INS_SHIFT;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_w >= cnt_w) begin
                                fin        = 1'b1;
                                fin_status = ST_BADPOS;
                            end else begin
                                mem_raddr = pos_c[AW-1:0];
                                n_state   = S_RM_GRAB;
                            end
                        end
                        OP_READ: begin
                            if (pos_w >= cnt_w) begin
                                fin        = 1'b1;
                                fin_status = ST_BADPOS;
                            end else begin
                                mem_raddr = pos_c[AW-1:0];
                                n_state   = S_RD_WAIT;
                            end
                        end
                        OP_WRITE: begin
                            fin = 1'b1;
                            if (i_ctl.null_h) begin
                                fin_status = ST_NULL;
                            end else if (pos_w >= cnt_w) begin
                                fin_status = ST_BADPOS;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_c[AW-1:0];
                                mem_wdata = i_handle;
                            end
                        end
                        OP_FIND: begin
                            if (i_ctl.null_h) begin
                                fin        = 1'b1;
                                fin_status = ST_NULL;
                            end else if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_MISS;
                            end else begin
                                mem_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_FIND;
                            end
                        end
                        OP_CLEAR: begin
                            fin     = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // r_rdata holds entry r_idx-1; move it up one place
            S_INS_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                if (idx_dn1 == r_pos) begin
                    n_state = S_INS_PLACE;
                end else begin
                    mem_raddr = idx_dn2[AW-1:0];
                    n_idx     = idx_dn1;
                end
            end

            S_INS_PLACE: begin
                fin       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = r_h;
                n_count   = cnt_up1;
            end

            S_RM_GRAB: begin
                n_hout = r_rdata;
                if (rpos_up1 == r_count) begin
                    fin      = 1'b1;
                    fin_hout = r_rdata;
                    n_count  = cnt_dn1;
                end else begin
                    mem_raddr = rpos_up1[AW-1:0];
                    n_idx     = r_pos;
                    n_state   = S_RM_SHIFT;
                end
            end

            // r_rdata holds entry r_idx+1; move it down one place
            S_RM_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                if (idx_up2 == r_count) begin
                    fin      = 1'b1;
                    fin_hout = r_hout;
                    n_count  = cnt_dn1;
                end else begin
                    mem_raddr = idx_up2[AW-1:0];
                    n_idx     = idx_up1;
                end
            end

            S_RD_WAIT: begin
                fin      = 1'b1;
                fin_hout = r_rdata;
            end

            // r_rdata holds entry r_idx
            S_FIND: begin
                if (r_rdata == r_h) begin
                    fin       = 1'b1;
                    fin_where = r_idx;
                end else if (idx_up1 == r_count) begin
                    fin        = 1'b1;
                    fin_status = ST_MISS;
                end else begin
                    mem_raddr = idx_up1[AW-1:0];
                    n_idx     = idx_up1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end

        n_res_valid  = r_res_valid && !i_res_pop;
        n_res_status = r_res_status;
        n_res_hout   = r_res_hout;
        n_res_where  = r_res_where;
        n_res_count  = r_res_count;
        if (fin) begin
            n_res_valid  = 1'b1;
            n_res_status = fin_status;
            n_res_hout   = fin_hout;
            n_res_where  = fin_where;
            n_res_count  = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_h          <= n_h;
        r_hout       <= n_hout;
        r_res_status <= n_res_status;
        r_res_hout   <= n_res_hout;
        r_res_where  <= n_res_where;
        r_res_count  <= n_res_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_status     = r_res_status;
    assign o_handle_out = HANDLE_W'(r_res_hout);
    assign o_found_at   = POS_W'(r_res_where);
    assign o_count      = COUNT_W'(r_res_count);

endmodule
`default_nettype wire

### sv/indexed_list_engine.sv
// Top level of the indexed list engine: front end, back end and their hookup.
`timescale 1ns / 1ps
`default_nettype none
// Indexed list engine: an ordered list of nonzero handles held in a store of
// CAPACITY entries with one read and one write port. Items are commands
// (append, insert, remove, read, write, find, clear) pushed through a
// queue-style port; each item yields exactly one result with a status, a
// handle (read or removed), a find position and the entry count after the
// command. Handles are taken modulo 2^HANDLE_BITS; zero is refused as null.
// A front end decodes items into a two-entry queue; a back end runs them one
// at a time against the store and parks the result in an output register;
// the queue still takes items while a result waits, but the back end starts
// none until it is popped. Append, write, clear, unused commands and errors
// finish from idle; read waits for the registered store read; insert shifts
// entries up from the tail, then places the handle; remove shifts later
// entries down; find compares from the head until a hit or the end. These
// walks go one entry per cycle, so they limit the rate. Results are registered
// and appear in the cycle after the back end finishes. No clearing pass is
// needed after reset: only entries below the count are ever read.
module indexed_list_engine #(
    parameter int CAPACITY    = ile_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = ile_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [ile_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [ile_pkg::POS_W-1:0]    i_position,
    input  wire logic [ile_pkg::HANDLE_W-1:0] i_handle,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [ile_pkg::STATUS_W-1:0]      o_status,
    output logic [ile_pkg::HANDLE_W-1:0]      o_handle_out,
    output logic [ile_pkg::POS_W-1:0]         o_found_at,
    output logic [ile_pkg::COUNT_W-1:0]       o_count
);
    import ile_pkg::*;

    // Stored handle width: handles arrive on a 32-bit port, so anything above
    // that is always zero
    localparam int StoreBits = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    logic                 q_valid;
    logic                 q_pop;
    t_ctl                 q_ctl;
    logic [StoreBits-1:0] q_handle;
    logic                 res_valid;

    // Decode and buffer incoming items
    ile_front #(
        .STORE_BITS (StoreBits)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .i_handle   (i_handle),
        .o_valid    (q_valid),
        .i_pop      (q_pop),
        .o_ctl      (q_ctl),
        .o_handle   (q_handle)
    );

    // Execute items against the store; one result register on the way out
    ile_back #(
        .CAPACITY   (CAPACITY),
        .STORE_BITS (StoreBits)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_ctl        (q_ctl),
        .i_handle     (q_handle),
        .o_res_valid  (res_valid),
        .i_res_pop    (pop),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_found_at   (o_found_at),
        .o_count      (o_count)
    );

    assign empty = !res_valid;

endmodule
`default_nettype wire

### test/list_result_checker.sv
// Checker for the indexed list engine: tracks the list, predicts every result and compares it.
`timescale 1ns / 1ps
module list_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [ile_pkg::CMD_W-1:0]         i_cmd,
    input  logic [ile_pkg::POS_W-1:0]         i_position,
    input  logic [ile_pkg::HANDLE_W-1:0]      i_handle,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [ile_pkg::STATUS_W-1:0]      i_status,
    input  logic [ile_pkg::HANDLE_W-1:0]      i_handle_out,
    input  logic [ile_pkg::POS_W-1:0]         i_found_at,
    input  logic [ile_pkg::COUNT_W-1:0]       i_count,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_full_refusals,
    output int                                o_find_hits,
    output logic [ile_pkg::COUNT_W-1:0]       o_list_count
);
    import ile_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle_out;
        logic [POS_W-1:0]    found_at;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    logic [HANDLE_W-1:0] list_store [DEPTH];
    logic [COUNT_W-1:0]  list_len;
    t_list_result        expected_results [$];

    // Runs one command on the shadow list; any error leaves the list untouched.
    function automatic t_list_result apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [HANDLE_W-1:0] h);
        t_list_result       r;
        logic [COUNT_W-1:0] p;
        r = '0;
        p = COUNT_W'(pos);
        case (cmd)
            CMD_APPEND: begin
                if (h == '0) r.status = ST_NULL;
                else if (list_len >= COUNT_W'(DEPTH)) r.status = ST_FULL;
                else begin
                    list_store[list_len] = h;
                    list_len = list_len + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (h == '0) r.status = ST_NULL;
                else if (p > list_len) r.status = ST_BADPOS;
                else if (list_len >= COUNT_W'(DEPTH)) r.status = ST_FULL;
                else begin
                    for (int i = int'(list_len); i > int'(p); i--)
                        list_store[i] = list_store[i-1];
                    list_store[p] = h;
                    list_len = list_len + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (p >= list_len) r.status = ST_BADPOS;
                else begin
                    r.handle_out = list_store[p];
                    for (int i = int'(p); i + 1 < int'(list_len); i++)
                        list_store[i] = list_store[i+1];
                    list_len = list_len - 1'b1;
                end
            end
            CMD_READ: begin
                if (p >= list_len) r.status = ST_BADPOS;
                else r.handle_out = list_store[p];
            end
            CMD_WRITE: begin
                if (h == '0) r.status = ST_NULL;
                else if (p >= list_len) r.status = ST_BADPOS;
                else list_store[p] = h;
            end
            CMD_FIND: begin
                if (h == '0) r.status = ST_NULL;
                else begin
                    r.status = ST_MISS;
                    for (int i = 0; i < int'(list_len); i++) begin
                        if (list_store[i] == h) begin
                            r.status   = ST_OK;
                            r.found_at = POS_W'(i);
                            break;
                        end
                    end
                end
            end
            CMD_CLEAR: list_len = '0;
            default: ;
        endcase
        r.count = list_len;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            o_mismatches++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            list_len = '0;
            expected_results.delete();
            o_mismatches    = 0;
            o_checked       = 0;
            o_full_refusals = 0;
            o_find_hits     = 0;
        end else begin
            // result side first: an item taken at this edge cannot be answered at it
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    $display({"%0t ns: result with no command waiting, ",
                              "expected none actual %h %h %h %h"},
                             $time, i_status, i_handle_out, i_found_at, i_count);
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("handle_out", want.handle_out, i_handle_out);
                    check_field("found_at", 32'(want.found_at), 32'(i_found_at));
                    check_field("count", 32'(want.count), 32'(i_count));
                end
            end
            if (push && !full) begin
                want = apply_list_cmd(i_cmd, i_position, i_handle);
                if (want.status == ST_FULL) o_full_refusals++;
                if (i_cmd == CMD_FIND && want.status == ST_OK) o_find_hits++;
                expected_results.push_back(want);
            end
        end
        o_pending    = expected_results.size();
        o_list_count = list_len;
    end

endmodule

### test/tb.sv
// Testbench top of the indexed list engine: stimulus, handshakes, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
    import ile_pkg::*;

    localparam int ITEMS        = 1900;  // random commands after the directed run
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving before giving up
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 80;    // wait after the last result is popped

    // the one command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef enum {GEN_GROW, GEN_SHRINK, GEN_MIX, GEN_NOISE} t_gen_kind;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [CMD_W-1:0]    i_cmd;
    logic [POS_W-1:0]    i_position;
    logic [HANDLE_W-1:0] i_handle;
    logic                empty;
    logic                pop;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [POS_W-1:0]    o_found_at;
    logic [COUNT_W-1:0]  o_count;

    // checker outputs
    int                  mismatches;
    int                  pending;
    int                  checked;
    int                  full_refusals;
    int                  find_hits;
    logic [COUNT_W-1:0]  list_count;

    int                  sent;
    int                  directed_sent;
    bit                  tx_burst;
    bit                  rx_burst;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    indexed_list_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_handle     (i_handle),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_found_at   (o_found_at),
        .o_count      (o_count)
    );

    list_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_position      (i_position),
        .i_handle        (i_handle),
        .empty           (empty),
        .pop             (pop),
        .i_status        (o_status),
        .i_handle_out    (o_handle_out),
        .i_found_at      (o_found_at),
        .i_count         (o_count),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals),
        .o_find_hits     (find_hits),
        .o_list_count    (list_count)
    );

    // Handles: mostly a small pool so finds hit and duplicates occur; some full
    // width randoms (every bit both ways), some near all-ones, some null.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        else if (r < 4) return $urandom;
        else if (r < 6) return {24'hFFFFFF, 8'($urandom_range(0, 7))};
        else return HANDLE_W'($urandom_range(1, 24));
    endfunction

    // Mostly a legal position for the current length; now and then anything.
    function automatic logic [POS_W-1:0] pick_pos(input int n, input bit for_insert);
        if ($urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, 63));
        else if (for_insert) return POS_W'($urandom_range(0, n));
        else if (n == 0) return POS_W'($urandom_range(0, 63));
        else return POS_W'($urandom_range(0, n - 1));
    endfunction

    // Called at a falling edge, so the checker's list length is settled.
    task automatic make_item(input t_gen_kind kind, output logic [CMD_W-1:0] c,
                             output logic [POS_W-1:0] p, output logic [HANDLE_W-1:0] h);
        int n;
        int r;
        n = int'(list_count);
        h = pick_handle();
        case (kind)
            GEN_GROW: begin
                c = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
            end
            GEN_SHRINK: begin
                r = $urandom_range(0, 9);
                c = (r < 7) ? CMD_REMOVE : (r < 8) ? CMD_READ : CMD_FIND;
            end
            GEN_MIX: begin
                r = $urandom_range(0, 39);
                if (r < 9) c = CMD_APPEND;
                else if (r < 18) c = CMD_INSERT;
                else if (r < 26) c = CMD_REMOVE;
                else if (r < 30) c = CMD_READ;
                else if (r < 34) c = CMD_WRITE;
                else if (r < 38) c = CMD_FIND;
                else if (r < 39) c = CMD_CLEAR;
                else c = CMD_UNUSED;
            end
            default: begin
                c = CMD_W'($urandom_range(0, 7));
                if ($urandom_range(0, 3) == 0) h = '0;
                else h = $urandom;
            end
        endcase
        if (kind == GEN_NOISE) p = POS_W'($urandom_range(0, 63));
        else p = pick_pos(n, c == CMD_INSERT);
    endtask

    // Sender gap: a random idle gap before each item, with bursts of back-to-back items.
    // Leaves us at a falling edge ready to drive.
    task automatic tx_gap();
        int gap;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
    endtask

    // Drive at the falling edge, then hold until the item is taken.
    task automatic drive_item(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                              input logic [HANDLE_W-1:0] h);
        push       <= 1'b1;
        i_cmd      <= c;
        i_position <= p;
        i_handle   <= h;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    task automatic send(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                        input logic [HANDLE_W-1:0] h);
        tx_gap();
        drive_item(c, p, h);
    endtask

    task automatic send_gen(input t_gen_kind kind);
        logic [CMD_W-1:0]    c;
        logic [POS_W-1:0]    p;
        logic [HANDLE_W-1:0] h;
        tx_gap();
        make_item(kind, c, p, h);
        drive_item(c, p, h);
    endtask

    // Sender stays quiet until every outstanding result has been popped.
    task automatic hold_until_drained();
        do begin
            @(negedge i_clk);
            push <= 1'b0;
        end while (pending != 0);
    endtask

    // Stimulus
    initial begin
        int n;
        int pick;
        bit paused;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_cmd      = CMD_APPEND;
        i_position = '0;
        i_handle   = '0;
        sent       = 0;
        tx_burst   = 1'b0;
        paused     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty list, extremes, check order, every command ---
        send(CMD_READ,   6'd0,  32'd0);           // empty: bad position
        send(CMD_REMOVE, 6'd0,  32'd0);           // empty: bad position
        send(CMD_FIND,   6'd0,  32'd5);           // empty list is a miss
        send(CMD_FIND,   6'd0,  32'd0);           // null find
        send(CMD_APPEND, 6'd0,  32'd0);           // null append
        send(CMD_APPEND, 6'd63, 32'hFFFF_FFFF);   // largest handle
        send(CMD_APPEND, 6'd0,  32'd1);           // smallest handle
        send(CMD_INSERT, 6'd0,  32'hA5A5_5A5A);   // insert at head
        send(CMD_INSERT, 6'd3,  32'h8000_0000);   // insert at count = append
        send(CMD_INSERT, 6'd5,  32'd7);           // one past count: bad position
        send(CMD_INSERT, 6'd63, 32'd0);           // null wins over bad position
        send(CMD_INSERT, 6'd2,  32'h7FFF_FFFF);   // mid-list shift up
        send(CMD_READ,   6'd4,  32'd0);           // last entry
        send(CMD_READ,   6'd63, 32'd0);           // bad position
        send(CMD_WRITE,  6'd1,  32'h1234_5678);
        send(CMD_WRITE,  6'd5,  32'd9);           // at count: bad position
        send(CMD_WRITE,  6'd63, 32'd0);           // null wins over bad position
        send(CMD_FIND,   6'd0,  32'd1);
        send(CMD_FIND,   6'd0,  32'h8000_0000);   // hit at the tail
        send(CMD_FIND,   6'd0,  32'hDEAD_BEEF);   // miss
        send(CMD_REMOVE, 6'd0,  32'd0);           // head
        send(CMD_REMOVE, 6'd3,  32'd0);           // tail
        send(CMD_REMOVE, 6'd1,  32'd0);           // middle, shift down
        send(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);   // no operation
        send(CMD_CLEAR,  6'd0,  32'd0);
        send(CMD_READ,   6'd0,  32'd0);           // stale entries stay hidden
        directed_sent = sent;
        hold_until_drained();

        // --- random: runs that fill to capacity, drain, mix, or throw noise ---
        while (sent < directed_sent + ITEMS) begin
            if (!paused && sent >= directed_sent + ITEMS / 2) begin
                paused = 1'b1;
                hold_until_drained();
            end
            @(negedge i_clk);
            push <= 1'b0;
            n    = int'(list_count);
            pick = $urandom_range(0, 9);
            if (pick < 3) repeat (70 - n) send_gen(GEN_GROW);       // runs past full
            else if (pick < 5) repeat (n + 4) send_gen(GEN_SHRINK);
            else if (pick < 9) repeat ($urandom_range(20, 50)) send_gen(GEN_MIX);
            else repeat (10) send_gen(GEN_NOISE);
        end
        @(negedge i_clk);
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d commands (%0d directed), list filled and drained repeatedly",
                 sent, directed_sent);
        $display("Compared %0d results: %0d refused on a full list, %0d find hits",
                 checked, full_refusals, find_hits);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random pop gaps, plus one long hold-off so the engine backs up
    initial begin : rx
        int gap;
        int pops;
        pop      = 1'b0;
        pops     = 0;
        rx_burst = 1'b0;
        do @(negedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (pops == 150) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge i_clk);
                pop <= 1'b0;
            end
            @(negedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            pops++;
        end
    end

    // Watchdog: gives up when neither side moves an item for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) stalled = 0;
            else stalled++;
        end
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
sv/ile_pkg.sv
sv/ile_front.sv
sv/ile_back.sv
sv/indexed_list_engine.sv
test/list_result_checker.sv
test/tb.sv
